FILE: rtl/fac_pkg.sv
// package for the fully associative write-back cache
// geometry constants, request/response payload types and function codes
package fac_pkg;
	localparam int SLOTS      = 64;
	localparam int LINE_BYTES = 64;
	localparam int MEM_BYTES  = 65536;
	localparam int LINE_WORDS = LINE_BYTES / 4;
	localparam int MEM_WORDS  = MEM_BYTES / 4;
	localparam int AW  = $clog2(MEM_BYTES);
	localparam int OW  = $clog2(LINE_BYTES);
	localparam int TW  = AW - OW;
	localparam int SW  = $clog2(SLOTS);
	localparam int WW  = $clog2(LINE_WORDS);
	localparam int MW  = $clog2(MEM_WORDS);
	localparam int CW  = SW + WW;
	localparam logic [15:0] LFSR_MASK = 16'hB400;

	localparam logic [1:0] FUNC_RD_BYTE = 2'd0;
	localparam logic [1:0] FUNC_RD_WORD = 2'd1;
	localparam logic [1:0] FUNC_WR_BYTE = 2'd2;
	localparam logic [1:0] FUNC_WR_WORD = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] address;
		logic [31:0] wdata;
	} req_t;

	typedef struct packed {
		logic [31:0] rdata;
		logic        hit;
		logic        misaligned;
	} rsp_t;
endpackage

FILE: rtl/fac_if.sv
// valid/ready channel interface for the cache
// depends on fac_pkg for payload types
interface fac_req_if;
	fac_pkg::req_t data;
	logic valid;
	logic ready;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fac_rsp_if;
	fac_pkg::rsp_t data;
	logic valid;
	logic ready;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/fully_assoc_writeback_cache.sv
// fully associative write-back write-allocate cache with internal backing memory
// depends on fac_pkg and the channel interfaces in fac_if.sv
//
// usage: requests enter on req (func, address, wdata); one response per request
// leaves on rsp (rdata, hit, misaligned). one request is in flight at a time.
// flow: a misaligned word access is answered from idle with no tag search. the
// tag search walks the slots one per cycle through the tag memory and ends early
// on a hit. a miss reads the victim tag, writes the victim line back word by word
// when the victim is dirty, and fills the line word by word, each word through
// the single port of the backing and line memories. the access reads the line
// word, then writes it or captures the read data; ST_RESP then raises the response.
// throughput is therefore set by the sequential tag walk and the line copies.
// reset: valid and dirty bits clear at once; the backing memory is then cleared
// by a pass over MEM_WORDS words while req.ready stays low. lfsr starts at 1.
// stall: the response sits in an output register until taken; the next request is
// accepted only when that register is free.
module fully_assoc_writeback_cache (
	input logic clk,
	input logic arst_n,
	fac_req_if.sink req,
	fac_rsp_if.source rsp
);
	import fac_pkg::*;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_SRCH  = 4'd2;
	localparam logic [3:0] ST_CHK   = 4'd3;
	localparam logic [3:0] ST_VICT  = 4'd4;
	localparam logic [3:0] ST_WB    = 4'd5;
	localparam logic [3:0] ST_FILL  = 4'd6;
	localparam logic [3:0] ST_ACC   = 4'd7;
	localparam logic [3:0] ST_ACC2  = 4'd8;
	localparam logic [3:0] ST_RESP  = 4'd9;

	logic [TW-1:0] tag_mem [SLOTS];
	logic [31:0] line_mem [SLOTS*LINE_WORDS];
	logic [31:0] back_mem [MEM_WORDS];
	logic [SLOTS-1:0] valid_q, dirty_q;

	logic [3:0] state_q;
	req_t req_q;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic [15:0] lfsr_q;
	logic [SW-1:0] slot_q;
	logic [SW:0] scan_q;
	logic [WW:0] cnt_q;
	logic [MW-1:0] clr_q;
	logic [TW-1:0] vtag_q;
	logic [TW-1:0] tag_rd_q;
	logic [31:0] line_rd_q, back_rd_q;
	logic hit_q;

	// memory port controls
	logic tag_re, tag_we, line_we, back_we;
	logic [SW-1:0] tag_ra;
	logic [CW-1:0] line_a;
	logic [MW-1:0] back_a;
	logic [31:0] line_wd, back_wd;

	logic [TW-1:0] rq_tag;
	logic [WW-1:0] rq_widx;
	logic [1:0] rq_byte;
	logic [15:0] lfsr_nx;
	logic [4:0] sh;
	logic [31:0] bmask, merged;

	assign rq_tag  = req_q.address[AW-1:OW];
	assign rq_widx = req_q.address[OW-1:2];
	assign rq_byte = req_q.address[1:0];
	assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_MASK) : (lfsr_q >> 1);
	assign sh = {rq_byte, 3'b000};
	assign bmask = 32'hFF << sh;
	assign merged = (line_rd_q & ~bmask) | ({24'd0, req_q.wdata[7:0]} << sh);

	assign req.ready = (state_q == ST_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	always_comb begin
		tag_ra  = scan_q[SW-1:0];
		tag_re  = 1'b0;
		tag_we  = 1'b0;
		line_we = 1'b0;
		back_we = 1'b0;
		line_a  = {slot_q, rq_widx};
		back_a  = clr_q;
		line_wd = back_rd_q;
		back_wd = line_rd_q;
		unique case (state_q)
			ST_CLEAR: begin
				back_we = 1'b1;
				back_wd = '0;
			end
			ST_SRCH: tag_re = 1'b1;
			ST_VICT: begin
				tag_ra = slot_q;
				tag_re = 1'b1;
			end
			ST_WB: begin
				// cnt 0..LINE_WORDS-1 read line; cnt 1..LINE_WORDS write the registered word to backing
				line_a = {slot_q, cnt_q[WW-1:0]};
				back_a = {vtag_q, cnt_q[WW-1:0] - 1'b1};
				back_we = (cnt_q != '0);
			end
			ST_FILL: begin
				back_a = {rq_tag, cnt_q[WW-1:0]};
				line_a = {slot_q, cnt_q[WW-1:0] - 1'b1};
				line_we = (cnt_q != '0);
				tag_we = (cnt_q == '0);
			end
			ST_ACC: ;
			ST_ACC2: begin
				line_we = req_q.func[1];
				line_wd = req_q.func[0] ? req_q.wdata : merged;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tag_we) tag_mem[slot_q] <= rq_tag;
		if (tag_re) tag_rd_q <= tag_mem[tag_ra];
		if (line_we) line_mem[line_a] <= line_wd;
		line_rd_q <= line_mem[line_a];
		if (back_we) back_mem[back_a] <= back_wd;
		back_rd_q <= back_mem[back_a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			valid_q <= '0;
			dirty_q <= '0;
			rsp_valid_q <= 1'b0;
			lfsr_q <= 16'd1;
			clr_q <= '0;
			scan_q <= '0;
			cnt_q <= '0;
			slot_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MW'(MEM_WORDS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						req_q <= req.data;
						if (req.data.func[0] && req.data.address[1:0] != 2'b00) begin
							rsp_q <= '{rdata: 32'd0, hit: 1'b0, misaligned: 1'b1};
							rsp_valid_q <= 1'b1;
						end else begin
							scan_q <= '0;
							state_q <= ST_SRCH;
						end
					end
				end
				ST_SRCH: begin
					// tag of slot scan_q-1 is in tag_rd_q
					if (scan_q != '0 && valid_q[slot_q] && tag_rd_q == rq_tag) begin
						hit_q <= 1'b1;
						state_q <= ST_ACC;
					end else if (scan_q == (SW+1)'(SLOTS)) begin
						hit_q <= 1'b0;
						lfsr_q <= lfsr_nx;
						slot_q <= lfsr_nx[SW-1:0];
						state_q <= ST_VICT;
					end else begin
						slot_q <= scan_q[SW-1:0];
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_VICT: state_q <= ST_CHK;
				ST_CHK: begin
					vtag_q <= tag_rd_q;
					cnt_q <= '0;
					state_q <= (valid_q[slot_q] && dirty_q[slot_q]) ? ST_WB : ST_FILL;
				end
				ST_WB: begin
					if (cnt_q == (WW+1)'(LINE_WORDS)) begin
						cnt_q <= '0;
						state_q <= ST_FILL;
					end else cnt_q <= cnt_q + 1'b1;
				end
				ST_FILL: begin
					if (cnt_q == (WW+1)'(LINE_WORDS)) begin
						valid_q[slot_q] <= 1'b1;
						dirty_q[slot_q] <= 1'b0;
						state_q <= ST_ACC;
					end else cnt_q <= cnt_q + 1'b1;
				end
				ST_ACC: state_q <= ST_ACC2;
				ST_ACC2: begin
					if (req_q.func[1]) dirty_q[slot_q] <= 1'b1;
					rsp_q.hit <= hit_q;
					rsp_q.misaligned <= 1'b0;
					case (req_q.func)
						FUNC_RD_WORD: rsp_q.rdata <= line_rd_q;
						FUNC_RD_BYTE: rsp_q.rdata <= (line_rd_q >> sh) & 32'hFF;
						default: rsp_q.rdata <= 32'd0;
					endcase
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					rsp_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/fac_checker.sv
// port-level assertions for the cache, bound to the top level
// depends on fac_pkg and the channel interfaces
module fac_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic [1:0] req_func,
	input logic [1:0] req_alo,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_hit,
	input logic rsp_mis
);
	import fac_pkg::*;

	// one request in flight: no accept while a response is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready) else $error("accept while response pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");
	a_mis: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_func[0] && req_alo != 2'b00 |=> rsp_valid && rsp_mis)
		else $error("misaligned word not flagged");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_hit && rsp_mis)) else $error("hit on misaligned");
endmodule

bind fully_assoc_writeback_cache fac_checker u_fac_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.req_func(req.data.func), .req_alo(req.data.address[1:0]),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_hit(rsp.data.hit), .rsp_mis(rsp.data.misaligned)
);
